// File: design/rmj_pkg.sv
package rmj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int XW        = 32;
    localparam int LIM_W     = 16;
    localparam int SQ_W      = 66;
    localparam int ROOT_W    = 32;
    localparam int QW        = 32;
    localparam int DEN_W     = 96;
    localparam int NUM_W     = 96 + FRAC_BITS;
    localparam int CMP_W     = DEN_W + QW;
    localparam int LANES     = 6;
    localparam int NCELL     = 32;

    localparam int L_RANGE_PX   = 0;
    localparam int L_RANGE_PY   = 1;
    localparam int L_BEARING_PX = 2;
    localparam int L_BEARING_PY = 3;
    localparam int L_RATE_PX    = 4;
    localparam int L_RATE_PY    = 5;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(7);
    localparam logic [QW-1:0]    ONE_FIX     = QW'(1) << FRAC_BITS;
    localparam logic [QW-1:0]    SAT_POS     = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0]    SAT_NEG     = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic              sx;
        logic              sy;
        logic [XW-1:0]     mx;
        logic [XW-1:0]     my;
        logic              cneg;
        logic [63:0]       cmag;
        logic [63:0]       c1;
        logic              near;
        logic [SQ_W-1:0]   rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] rem;
        logic [LANES-1:0][DEN_W-1:0] den;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][QW-1:0]    q;
        logic                        near;
    } dv_t;

endpackage

// File: design/rmj_sqrt_cell.sv
module rmj_sqrt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic [4:0]    bit_idx,
    input  logic          in_valid,
    input  rmj_pkg::sq_t  in_data,
    output logic          out_valid,
    output rmj_pkg::sq_t  out_data
);

    logic [rmj_pkg::SQ_W-1:0] trial;
    logic                     ge;
    logic                     valid_reg;
    rmj_pkg::sq_t             data_reg;
    rmj_pkg::sq_t             data_next;

    // trial = 2*root*2^j + 4^j, root bits below j still zero
    always_comb
    begin
        trial = (rmj_pkg::SQ_W'(in_data.root) << (6'(bit_idx) + 6'd1))
              + (rmj_pkg::SQ_W'(1) << {bit_idx, 1'b0});
        ge = in_data.rem >= trial;
        data_next = in_data;
        if (ge)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = in_data.root | (rmj_pkg::ROOT_W'(1) << bit_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: design/rmj_div_cell.sv
module rmj_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic [4:0]    bit_idx,
    input  logic          in_valid,
    input  rmj_pkg::dv_t  in_data,
    output logic          out_valid,
    output rmj_pkg::dv_t  out_data
);

    logic [rmj_pkg::LANES-1:0][rmj_pkg::CMP_W-1:0] shifted;
    logic                                          valid_reg;
    rmj_pkg::dv_t                                  data_reg;
    rmj_pkg::dv_t                                  data_next;

    // one quotient bit per lane; the top cell's bit marks saturation
    always_comb
    begin
        data_next = in_data;
        for (int l = 0; l < rmj_pkg::LANES; l++)
        begin
            shifted[l] = rmj_pkg::CMP_W'(in_data.den[l]) << bit_idx;
            if (rmj_pkg::CMP_W'(in_data.rem[l]) >= shifted[l])
            begin
                data_next.rem[l] = in_data.rem[l] - shifted[l][rmj_pkg::NUM_W-1:0];
                data_next.q[l]   = in_data.q[l] | (rmj_pkg::QW'(1) << bit_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: design/radar_measurement_jacobian.sv
// Radar measurement Jacobian for a constant-velocity track state.
// Input stream: one transaction per state, s_tdata = pos_x, pos_y, vel_x,
// vel_y (signed Q16.16, pos_x lowest). Output stream: one transaction per
// state, m_tdata holds the six Jacobian entries (range_by_px lowest) and
// m_tuser the near_zero flag; when set, all six entries read 1.0.
// The range-rate-by-velocity entries equal range_by_px/range_by_py.
// cfg_we/cfg_wdata write near_zero_limit (Q0.16 bound on squared range);
// write it only while no transaction is in flight.
// Two stages form the squares and cross products, a row of 32 root cells
// yields one root bit each, two stages form the wide numerators and
// denominators, and a row of 32 divider cells yields one quotient bit each
// for six lanes in parallel. Throughput: one transaction per cycle. The
// whole pipeline advances when the output register is empty or taken, so a
// stall on m_tready holds every stage and drops s_tready in the same cycle.
// Reset clears all stage valid bits and sets near_zero_limit to 7.
module radar_measurement_jacobian (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // range_by_px, range_by_py, bearing_by_px,
                                    // bearing_by_py, rate_by_px, rate_by_py
    output logic         m_tuser,   // near_zero
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);

    localparam int F  = rmj_pkg::FRAC_BITS;
    localparam int XW = rmj_pkg::XW;
    localparam int NC = rmj_pkg::NCELL;

    logic adv;
    logic [rmj_pkg::LIM_W-1:0] limit_reg;

    logic signed [XW-1:0] pos_x, pos_y, vel_x, vel_y;
    logic [XW-1:0]        mx_next, my_next;

    logic                 f1_valid_reg;
    logic                 f1_sx_reg, f1_sy_reg;
    logic [XW-1:0]        f1_mx_reg, f1_my_reg;
    logic [63:0]          f1_pxx_reg, f1_pyy_reg;
    logic signed [63:0]   f1_a_reg, f1_b_reg;

    rmj_pkg::sq_t         sq_next;
    logic                 sq_valid_reg;
    rmj_pkg::sq_t         sq_reg;
    logic [NC:0]          sq_v;
    rmj_pkg::sq_t         sq_d [NC+1];

    logic                 m1_valid_reg;
    logic                 m1_sx_reg, m1_sy_reg, m1_cneg_reg, m1_cnz_reg, m1_near_reg;
    logic [XW-1:0]        m1_mx_reg, m1_my_reg;
    logic [63:0]          m1_c1_reg;
    logic [rmj_pkg::ROOT_W-1:0] m1_r_reg;
    logic [63:0]          m1_pyl_reg, m1_pyh_reg, m1_pxl_reg, m1_pxh_reg;
    logic [63:0]          m1_cl_reg, m1_ch_reg;

    rmj_pkg::dv_t         dv_next;
    logic                 dv_valid_reg;
    rmj_pkg::dv_t         dv_reg;
    logic [NC:0]          dv_v;
    rmj_pkg::dv_t         dv_d [NC+1];

    logic [rmj_pkg::LANES-1:0][rmj_pkg::QW-1:0] res;
    logic                 m_valid_reg;
    logic [191:0]         m_data_reg;
    logic                 m_user_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= rmj_pkg::LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // squares and cross products
    always_comb
    begin
        pos_x   = s_tdata[31:0];
        pos_y   = s_tdata[63:32];
        vel_x   = s_tdata[95:64];
        vel_y   = s_tdata[127:96];
        mx_next = pos_x[XW-1] ? XW'(-pos_x) : XW'(pos_x);
        my_next = pos_y[XW-1] ? XW'(-pos_y) : XW'(pos_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            dv_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= s_tvalid;
            sq_valid_reg <= f1_valid_reg;
            m1_valid_reg <= sq_v[NC];
            dv_valid_reg <= m1_valid_reg;
            m_valid_reg  <= dv_v[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_sx_reg  <= pos_x[XW-1];
            f1_sy_reg  <= pos_y[XW-1];
            f1_mx_reg  <= mx_next;
            f1_my_reg  <= my_next;
            f1_pxx_reg <= 64'(mx_next) * 64'(mx_next);
            f1_pyy_reg <= 64'(my_next) * 64'(my_next);
            f1_a_reg   <= 64'(vel_x) * 64'(pos_y);
            f1_b_reg   <= 64'(vel_y) * 64'(pos_x);
        end
    end

    // squared range, cross term magnitude, near-zero test
    always_comb
    begin
        sq_next.sx   = f1_sx_reg;
        sq_next.sy   = f1_sy_reg;
        sq_next.mx   = f1_mx_reg;
        sq_next.my   = f1_my_reg;
        sq_next.c1   = f1_pxx_reg + f1_pyy_reg;
        sq_next.cneg = f1_a_reg < f1_b_reg;
        sq_next.cmag = sq_next.cneg ? 64'(f1_b_reg - f1_a_reg) : 64'(f1_a_reg - f1_b_reg);
        sq_next.near = (sq_next.c1 == 64'd0) || (sq_next.c1 < (64'(limit_reg) << F));
        sq_next.rem  = rmj_pkg::SQ_W'(sq_next.c1);
        sq_next.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sq_reg <= sq_next;
    end

    assign sq_v[0] = sq_valid_reg;
    assign sq_d[0] = sq_reg;

    for (genvar k = 0; k < NC; k++)
    begin : g_sqrt
        rmj_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .bit_idx  (5'(NC - 1 - k)),
            .in_valid (sq_v[k]),
            .in_data  (sq_d[k]),
            .out_valid(sq_v[k+1]),
            .out_data (sq_d[k+1])
        );
    end

    // partial products of the wide numerators and denominator
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_sx_reg   <= sq_d[NC].sx;
            m1_sy_reg   <= sq_d[NC].sy;
            m1_cneg_reg <= sq_d[NC].cneg;
            m1_cnz_reg  <= sq_d[NC].cmag != 64'd0;
            m1_near_reg <= sq_d[NC].near;
            m1_mx_reg   <= sq_d[NC].mx;
            m1_my_reg   <= sq_d[NC].my;
            m1_c1_reg   <= sq_d[NC].c1;
            m1_r_reg    <= sq_d[NC].root;
            m1_pyl_reg  <= 64'(sq_d[NC].my) * 64'(sq_d[NC].cmag[31:0]);
            m1_pyh_reg  <= 64'(sq_d[NC].my) * 64'(sq_d[NC].cmag[63:32]);
            m1_pxl_reg  <= 64'(sq_d[NC].mx) * 64'(sq_d[NC].cmag[31:0]);
            m1_pxh_reg  <= 64'(sq_d[NC].mx) * 64'(sq_d[NC].cmag[63:32]);
            m1_cl_reg   <= 64'(sq_d[NC].c1[31:0]) * 64'(sq_d[NC].root);
            m1_ch_reg   <= 64'(sq_d[NC].c1[63:32]) * 64'(sq_d[NC].root);
        end
    end

    always_comb
    begin
        dv_next.q    = '0;
        dv_next.near = m1_near_reg;

        dv_next.rem[rmj_pkg::L_RANGE_PX] = rmj_pkg::NUM_W'(m1_mx_reg) << F;
        dv_next.den[rmj_pkg::L_RANGE_PX] = rmj_pkg::DEN_W'(m1_r_reg);
        dv_next.neg[rmj_pkg::L_RANGE_PX] = m1_sx_reg;

        dv_next.rem[rmj_pkg::L_RANGE_PY] = rmj_pkg::NUM_W'(m1_my_reg) << F;
        dv_next.den[rmj_pkg::L_RANGE_PY] = rmj_pkg::DEN_W'(m1_r_reg);
        dv_next.neg[rmj_pkg::L_RANGE_PY] = m1_sy_reg;

        dv_next.rem[rmj_pkg::L_BEARING_PX] = rmj_pkg::NUM_W'(m1_my_reg) << (2 * F);
        dv_next.den[rmj_pkg::L_BEARING_PX] = rmj_pkg::DEN_W'(m1_c1_reg);
        dv_next.neg[rmj_pkg::L_BEARING_PX] = !m1_sy_reg;

        dv_next.rem[rmj_pkg::L_BEARING_PY] = rmj_pkg::NUM_W'(m1_mx_reg) << (2 * F);
        dv_next.den[rmj_pkg::L_BEARING_PY] = rmj_pkg::DEN_W'(m1_c1_reg);
        dv_next.neg[rmj_pkg::L_BEARING_PY] = m1_sx_reg;

        dv_next.rem[rmj_pkg::L_RATE_PX] = (rmj_pkg::NUM_W'(m1_pyl_reg)
                                         + (rmj_pkg::NUM_W'(m1_pyh_reg) << 32)) << F;
        dv_next.den[rmj_pkg::L_RATE_PX] = rmj_pkg::DEN_W'(m1_cl_reg)
                                        + (rmj_pkg::DEN_W'(m1_ch_reg) << 32);
        dv_next.neg[rmj_pkg::L_RATE_PX] = m1_cnz_reg && (m1_sy_reg != m1_cneg_reg);

        dv_next.rem[rmj_pkg::L_RATE_PY] = (rmj_pkg::NUM_W'(m1_pxl_reg)
                                         + (rmj_pkg::NUM_W'(m1_pxh_reg) << 32)) << F;
        dv_next.den[rmj_pkg::L_RATE_PY] = dv_next.den[rmj_pkg::L_RATE_PX];
        dv_next.neg[rmj_pkg::L_RATE_PY] = m1_cnz_reg && (m1_sx_reg == m1_cneg_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg <= dv_next;
    end

    assign dv_v[0] = dv_valid_reg;
    assign dv_d[0] = dv_reg;

    for (genvar k = 0; k < NC; k++)
    begin : g_div
        rmj_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .bit_idx  (5'(NC - 1 - k)),
            .in_valid (dv_v[k]),
            .in_data  (dv_d[k]),
            .out_valid(dv_v[k+1]),
            .out_data (dv_d[k+1])
        );
    end

    // sign, saturate, or force 1.0 on near-zero range
    always_comb
    begin
        for (int l = 0; l < rmj_pkg::LANES; l++)
        begin
            if (dv_d[NC].near)
                res[l] = rmj_pkg::ONE_FIX;
            else if (dv_d[NC].q[l][rmj_pkg::QW-1])
                res[l] = dv_d[NC].neg[l] ? rmj_pkg::SAT_NEG : rmj_pkg::SAT_POS;
            else if (dv_d[NC].neg[l])
                res[l] = rmj_pkg::QW'(-dv_d[NC].q[l]);
            else
                res[l] = dv_d[NC].q[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= res;
            m_user_reg <= dv_d[NC].near;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: design/rmj_checker.sv
module rmj_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic         m_tuser
);

    // a stalled output transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // the input side is ready exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output register");

    // near-zero range forces every entry to 1.0
    a_near: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            m_tdata[31:0] == rmj_pkg::ONE_FIX && m_tdata[63:32] == rmj_pkg::ONE_FIX &&
            m_tdata[95:64] == rmj_pkg::ONE_FIX && m_tdata[127:96] == rmj_pkg::ONE_FIX &&
            m_tdata[159:128] == rmj_pkg::ONE_FIX && m_tdata[191:160] == rmj_pkg::ONE_FIX)
        else $error("near-zero entries are not 1.0");

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
